FILE: rtl/spf_pkg.sv
// Shared types and constants for the sensor packet framer.
`default_nettype none

package spf_pkg;

  // Frame constants
  localparam logic [7:0] SyncByte0 = 8'hEF;
  localparam logic [7:0] SyncByte1 = 8'h01;
  localparam logic [7:0] AddrByte  = 8'hFF;
  localparam logic [7:0] TypeData  = 8'h02;
  localparam logic [7:0] TypeEnd   = 8'h08;

  // Register widths, defaults and limits
  localparam int unsigned PktSizeW  = 10;
  localparam int unsigned TmplSizeW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned ChunkW    = 9;

  localparam logic [PktSizeW-1:0]  PktSizeDefault  = 10'd128;
  localparam logic [PktSizeW-1:0]  PktSizeMin      = 10'd32;
  localparam logic [PktSizeW-1:0]  PktSizeMax      = 10'd256;
  localparam logic [TmplSizeW-1:0] TmplSizeDefault = 16'd512;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxPacketSize   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxTemplateSize = 1'b1;

  // Job queue depth between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // One classified input byte, handed from front to back
  typedef struct packed {
    logic [7:0]        data;
    logic              hdr;          // byte opens a chunk: send the header first
    logic              close;        // byte closes a chunk: send the checksum after
    logic              final_chunk;  // chunk is the last of the transfer
    logic [ChunkW-1:0] len;          // chunk size plus 2
    logic [15:0]       csum;         // checksum including this byte
  } spf_job_t;

endpackage

`default_nettype wire

FILE: rtl/spf_front.sv
// Front end: holds registers, accepts template bytes and classifies them into jobs.
`default_nettype none

module spf_front
  import spf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata,
  input  wire logic                 in_accept,
  input  wire logic [7:0]           in_data_byte,
  output spf_job_t                  job
);

  logic [PktSizeW-1:0]  packet_size_r;
  logic [TmplSizeW-1:0] template_size_r;
  logic [15:0]          bytes_sent_r, bytes_sent_nxt;
  logic [ChunkW-1:0]    chunk_left_r, chunk_left_nxt;
  logic [15:0]          running_sum_r, running_sum_nxt;
  logic                 chunk_final_r, chunk_final_nxt;

  logic                 start;
  logic [ChunkW-1:0]    ps_eff;
  logic [15:0]          remaining;
  logic [ChunkW-1:0]    size;
  logic                 size_final;
  logic [ChunkW-1:0]    len;
  logic [7:0]           type_byte;
  logic [15:0]          hdr_sum;
  logic [15:0]          new_sum;
  logic [ChunkW-1:0]    cur_left;
  logic                 cur_final;
  logic                 close;

  // Size and type of a chunk that would start with this byte
  always_comb begin
    start = (chunk_left_r == '0);
    if (packet_size_r < PktSizeMin || packet_size_r > PktSizeMax) begin
      ps_eff = PktSizeDefault[ChunkW-1:0];
    end else begin
      ps_eff = packet_size_r[ChunkW-1:0];
    end
    remaining = (template_size_r > bytes_sent_r) ? (template_size_r - bytes_sent_r) : '0;
    if (remaining == '0) begin
      size       = ChunkW'(1);
      size_final = 1'b1;
    end else if (remaining <= {{(16-ChunkW){1'b0}}, ps_eff}) begin
      size       = remaining[ChunkW-1:0];
      size_final = 1'b1;
    end else begin
      size       = ps_eff;
      size_final = 1'b0;
    end
    len       = size + ChunkW'(2);
    type_byte = size_final ? TypeEnd : TypeData;
    hdr_sum   = {15'd0, len[ChunkW-1]} + {8'd0, len[7:0]} + {8'd0, type_byte};
  end

  // Fold this byte into the open chunk
  always_comb begin
    cur_left  = start ? size : chunk_left_r;
    cur_final = start ? size_final : chunk_final_r;
    new_sum   = (start ? hdr_sum : running_sum_r) + {8'd0, in_data_byte};
    chunk_left_nxt = cur_left - ChunkW'(1);
    close     = (chunk_left_nxt == '0);
    bytes_sent_nxt  = (close && cur_final) ? '0 : bytes_sent_r + 16'd1;
    running_sum_nxt = close ? '0 : new_sum;
    chunk_final_nxt = close ? 1'b0 : cur_final;
  end

  // Build the job for the back end
  always_comb begin
    job.data        = in_data_byte;
    job.hdr         = start;
    job.close       = close;
    job.final_chunk = cur_final;
    job.len         = len;
    job.csum        = new_sum;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_size_r   <= PktSizeDefault;
      template_size_r <= TmplSizeDefault;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgIdxPacketSize:   packet_size_r   <= cfg_wdata[PktSizeW-1:0];
        CfgIdxTemplateSize: template_size_r <= cfg_wdata[TmplSizeW-1:0];
        default: ;
      endcase
    end
  end

  // Advance chunk state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_sent_r  <= '0;
      chunk_left_r  <= '0;
      running_sum_r <= '0;
      chunk_final_r <= 1'b0;
    end else if (in_accept) begin
      bytes_sent_r  <= bytes_sent_nxt;
      chunk_left_r  <= chunk_left_nxt;
      running_sum_r <= running_sum_nxt;
      chunk_final_r <= chunk_final_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spf_queue.sv
// Job queue between front and back ends.
`default_nettype none

module spf_queue
  import spf_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
)
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire spf_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output spf_job_t      head_job
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  spf_job_t            mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spf_back.sv
// Back end: expands each job into header, payload and checksum beats.
`default_nettype none

module spf_back
  import spf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire spf_job_t   head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_wire_byte,
  output logic            out_packet_end,
  output logic            out_transfer_end,
  output logic            out_run_last
);

  // Beat positions within one job
  localparam logic [3:0] PosSync0   = 4'd0;
  localparam logic [3:0] PosSync1   = 4'd1;
  localparam logic [3:0] PosAddr0   = 4'd2;
  localparam logic [3:0] PosAddr1   = 4'd3;
  localparam logic [3:0] PosAddr2   = 4'd4;
  localparam logic [3:0] PosAddr3   = 4'd5;
  localparam logic [3:0] PosType    = 4'd6;
  localparam logic [3:0] PosLenHi   = 4'd7;
  localparam logic [3:0] PosLenLo   = 4'd8;
  localparam logic [3:0] PosData    = 4'd9;
  localparam logic [3:0] PosCsumHi  = 4'd10;
  localparam logic [3:0] PosCsumLo  = 4'd11;

  logic        started_r;
  logic [3:0]  pos_r;
  logic        out_valid_r;
  logic [7:0]  wire_byte_r;
  logic        packet_end_r, transfer_end_r, run_last_r;

  logic        advance;
  logic [3:0]  cur_pos;
  logic        last_beat;
  logic [7:0]  beat_byte;

  assign out_valid        = out_valid_r;
  assign out_wire_byte    = wire_byte_r;
  assign out_packet_end   = packet_end_r;
  assign out_transfer_end = transfer_end_r;
  assign out_run_last     = run_last_r;

  // Pick the next beat of the head job
  always_comb begin
    advance   = head_valid && (!out_valid_r || !out_stall);
    cur_pos   = started_r ? pos_r : (head_job.hdr ? PosSync0 : PosData);
    last_beat = (cur_pos == PosCsumLo) || (cur_pos == PosData && !head_job.close);
    pop       = advance && last_beat;
    unique case (cur_pos) inside
      PosSync0:                               beat_byte = SyncByte0;
      PosSync1:                               beat_byte = SyncByte1;
      PosAddr0, PosAddr1, PosAddr2, PosAddr3: beat_byte = AddrByte;
      PosType:   beat_byte = head_job.final_chunk ? TypeEnd : TypeData;
      PosLenHi:  beat_byte = {7'd0, head_job.len[ChunkW-1]};
      PosLenLo:  beat_byte = head_job.len[7:0];
      PosCsumHi: beat_byte = head_job.csum[15:8];
      PosCsumLo: beat_byte = head_job.csum[7:0];
      default:   beat_byte = head_job.data;
    endcase
  end

  // Track the position inside the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pos_r     <= '0;
    end else if (advance) begin
      started_r <= !last_beat;
      pos_r     <= cur_pos + 4'd1;
    end
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wire_byte_r    <= beat_byte;
      packet_end_r   <= (cur_pos == PosCsumLo);
      transfer_end_r <= (cur_pos == PosCsumLo) && head_job.final_chunk;
      run_last_r     <= last_beat;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sensor_packet_framer_top.sv
// Top level of the sensor packet framer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall   | in_data_byte
//  out     | output    | out_valid / out_stall | out_wire_byte, out_packet_end,
//          |           |                      | out_transfer_end, out_run_last
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One output beat per cycle while a job is queued and out_stall is low; each payload
// byte is one beat, and a chunk adds header beats before its bytes and checksum beats after.
// The back end's one-beat-per-cycle output register sets the rate; the front end takes
// one byte per cycle while the job queue has room.
// Synchronous active-low reset clears all control state; registers return to 128 / 512.
// out_stall holds the output register; in_stall rises only when the job queue is full.
`default_nettype none

module sensor_packet_framer_top
  import spf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_data_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_wire_byte,
  output logic                     out_packet_end,
  output logic                     out_transfer_end,
  output logic                     out_run_last
);

  spf_job_t new_job, head_job;
  logic     q_full, head_valid, pop, in_accept;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  spf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_accept    (in_accept),
    .in_data_byte (in_data_byte),
    .job          (new_job)
  );

  spf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_job   (new_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  spf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wire_byte    (out_wire_byte),
    .out_packet_end   (out_packet_end),
    .out_transfer_end (out_transfer_end),
    .out_run_last     (out_run_last)
  );

endmodule

`default_nettype wire

FILE: rtl/spf_checker.sv
// Port-level checker for the sensor packet framer, bound to the top level.
`default_nettype none

module spf_checker
  import spf_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic [7:0]          in_data_byte,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [7:0]          out_wire_byte,
  input wire logic                out_packet_end,
  input wire logic                out_transfer_end,
  input wire logic                out_run_last
);

  // Hold a stalled input beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte))
    else $error("stalled input beat changed");

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wire_byte))
    else $error("stalled output beat changed");

  // Transfer end only on a packet's closing beat
  a_tend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_transfer_end |-> out_packet_end)
    else $error("transfer end without packet end");

  // Packet end always closes the run of its input byte
  a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_end |-> out_run_last)
    else $error("packet end not last of run");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sensor_packet_framer_top spf_checker u_spf_checker (.*);

`default_nettype wire

FILE: sim/tb_sensor_packet_framer_top.sv
// Self-checking testbench for the sensor packet framer: frames, checksums and end flags.
`timescale 1ns / 1ps

module tb_sensor_packet_framer_top
  import spf_pkg::*;
();

  localparam int unsigned RandomItems = 455;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 400_000;

  typedef enum logic [1:0] {
    IdleRecvHeavy,
    IdleSendHeavy,
    IdleOff
  } idle_mode_e;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       packet_end;
    logic       transfer_end;
    logic       run_last;
  } wire_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_data_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_wire_byte;
  logic                out_packet_end;
  logic                out_transfer_end;
  logic                out_run_last;

  // Framer image: registers and open-chunk state
  logic [PktSizeW-1:0]  pkt_size_reg = PktSizeDefault;
  logic [TmplSizeW-1:0] tmpl_size_reg = TmplSizeDefault;
  logic [15:0]          tmpl_sent = '0;
  logic [ChunkW-1:0]    chunk_owed = '0;
  logic [15:0]          chunk_sum = '0;
  logic                 chunk_final = 1'b0;

  logic [7:0]  pending_bytes[$];
  wire_beat_t  wire_beats_due[$];
  wire_beat_t  due_beat;
  idle_mode_e  idle_mode = IdleRecvHeavy;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned beats_checked = 0;
  int unsigned packets_seen = 0;
  int unsigned transfers_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;

  sensor_packet_framer_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wire_byte    (out_wire_byte),
    .out_packet_end   (out_packet_end),
    .out_transfer_end (out_transfer_end),
    .out_run_last     (out_run_last)
  );

  always #10 clk = ~clk;

  // Queue one wire beat that the framer owes
  task automatic owe_beat(input logic [7:0] b, input logic pend, input logic tend,
                          input logic last);
    wire_beat_t beat;
    beat.wire_byte    = b;
    beat.packet_end   = pend;
    beat.transfer_end = tend;
    beat.run_last     = last;
    wire_beats_due.push_back(beat);
  endtask

  // Advance the framer image by one template byte and queue the beats it causes
  task automatic frame_input_byte(input logic [7:0] data);
    int unsigned eff_size;
    int unsigned remaining;
    int unsigned size;
    logic [7:0]  type_byte;
    logic [15:0] len;
    logic        closing;
    if (chunk_owed == '0) begin
      eff_size = 32'(pkt_size_reg);
      if (pkt_size_reg < PktSizeMin || pkt_size_reg > PktSizeMax) begin
        eff_size = 32'(PktSizeDefault);
      end
      remaining = (tmpl_size_reg > tmpl_sent) ? 32'(tmpl_size_reg - tmpl_sent) : 0;
      if (remaining == 0) begin
        size = 1;
        chunk_final = 1'b1;
      end else if (remaining <= eff_size) begin
        size = remaining;
        chunk_final = 1'b1;
      end else begin
        size = eff_size;
        chunk_final = 1'b0;
      end
      type_byte = chunk_final ? TypeEnd : TypeData;
      len = 16'(size + 2);
      owe_beat(SyncByte0, 1'b0, 1'b0, 1'b0);
      owe_beat(SyncByte1, 1'b0, 1'b0, 1'b0);
      repeat (4) owe_beat(AddrByte, 1'b0, 1'b0, 1'b0);
      owe_beat(type_byte, 1'b0, 1'b0, 1'b0);
      owe_beat(len[15:8], 1'b0, 1'b0, 1'b0);
      owe_beat(len[7:0], 1'b0, 1'b0, 1'b0);
      chunk_sum = {8'd0, len[15:8]} + {8'd0, len[7:0]} + {8'd0, type_byte};
      chunk_owed = ChunkW'(size);
    end
    chunk_sum  = chunk_sum + {8'd0, data};
    tmpl_sent  = tmpl_sent + 16'd1;
    chunk_owed = chunk_owed - ChunkW'(1);
    closing    = (chunk_owed == '0);
    owe_beat(data, 1'b0, 1'b0, !closing);
    if (closing) begin
      owe_beat(chunk_sum[15:8], 1'b0, 1'b0, 1'b0);
      owe_beat(chunk_sum[7:0], 1'b1, chunk_final, 1'b1);
      if (chunk_final) tmpl_sent = '0;
      chunk_sum   = '0;
      chunk_final = 1'b0;
    end
  endtask

  function automatic bit roll_idle(input bit sender);
    int unsigned pct;
    case (idle_mode)
      IdleRecvHeavy: pct = sender ? 30 : 79;
      IdleSendHeavy: pct = sender ? 79 : 30;
      default:       pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Write one register while the framer is idle and mirror it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CfgIdxPacketSize) pkt_size_reg = value[PktSizeW-1:0];
    else tmpl_size_reg = value;
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every byte is taken and every owed beat has come out
  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || in_valid || wire_beats_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Sender: hold a stalled beat, otherwise offer the next byte or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_input_byte(in_data_byte);
        bytes_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && !roll_idle(1'b1)) begin
          in_valid     <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_cnt < HoldCycles) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= roll_idle(1'b0);
    end
  end

  // Check each accepted wire beat against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (wire_beats_due.size() == 0) begin
        $error("unexpected beat: wire_byte %0h", out_wire_byte);
        fail_count++;
      end else begin
        due_beat = wire_beats_due.pop_front();
        beats_checked++;
        if (out_packet_end) packets_seen++;
        if (out_transfer_end) transfers_seen++;
        if (out_wire_byte !== due_beat.wire_byte) begin
          $error("wire_byte: expected %0h, got %0h", due_beat.wire_byte, out_wire_byte);
          fail_count++;
        end
        if (out_packet_end !== due_beat.packet_end) begin
          $error("packet_end: expected %0b, got %0b", due_beat.packet_end, out_packet_end);
          fail_count++;
        end
        if (out_transfer_end !== due_beat.transfer_end) begin
          $error("transfer_end: expected %0b, got %0b", due_beat.transfer_end,
                 out_transfer_end);
          fail_count++;
        end
        if (out_run_last !== due_beat.run_last) begin
          $error("run_last: expected %0b, got %0b", due_beat.run_last, out_run_last);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL sensor_packet_framer_top");
      $finish;
    end
  end

  initial begin
    int unsigned     random_queued;
    int unsigned     count;
    logic [15:0]     value;
    bit              pressure_done;
    random_queued = 0;
    pressure_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out-of-range packet size with template already covered: one-byte final chunks
    write_reg(CfgIdxPacketSize, 16'd1023);
    write_reg(CfgIdxTemplateSize, 16'd0);
    @(negedge clk);
    pending_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    wait_for_drain();

    // Packet size just below the minimum, one-byte template
    write_reg(CfgIdxPacketSize, 16'd31);
    write_reg(CfgIdxTemplateSize, 16'd1);
    @(negedge clk);
    pending_bytes = '{8'hFF, 8'h00};
    wait_for_drain();

    // Just above the maximum; second transfer starts after the first ends
    write_reg(CfgIdxPacketSize, 16'd257);
    write_reg(CfgIdxTemplateSize, 16'd3);
    @(negedge clk);
    pending_bytes = '{8'h01, 8'h02, 8'hFE, 8'hAA, 8'h55};
    wait_for_drain();

    // Registers change mid-chunk: open chunk keeps its size and type
    write_reg(CfgIdxPacketSize, 16'd32);
    write_reg(CfgIdxTemplateSize, 16'd5);
    @(negedge clk);
    pending_bytes = '{8'h10, 8'h20};
    wait_for_drain();
    write_reg(CfgIdxPacketSize, 16'd256);
    write_reg(CfgIdxTemplateSize, 16'hFFFF);
    @(negedge clk);
    pending_bytes = '{8'h30, 8'h40, 8'h50};
    wait_for_drain();

    // Random phases; before each, the registers are rewritten at random or kept, or set for the hold phase
    while (random_queued < RandomItems) begin
      if (random_queued >= 2 * RandomItems / 3) idle_mode = IdleOff;
      else if (random_queued >= RandomItems / 3) idle_mode = IdleSendHeavy;
      else idle_mode = IdleRecvHeavy;

      if (idle_mode == IdleOff && !pressure_done) begin
        // Hold the output off long enough for the input to back up
        write_reg(CfgIdxPacketSize, 16'd32);
        write_reg(CfgIdxTemplateSize, 16'd200);
        @(negedge clk);
        hold_req = 1'b1;
        count = 40;
        pressure_done = 1'b1;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 11))
            0:       value = 16'd0;
            1:       value = 16'd31;
            2:       value = 16'd32;
            3:       value = 16'd256;
            4:       value = 16'd257;
            5:       value = 16'd1023;
            10:      value = 16'($urandom_range(0, 65535));
            11:      value = 16'($urandom_range(33, 255));
            default: value = 16'($urandom_range(32, 48));
          endcase
          write_reg(CfgIdxPacketSize, value);
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 9))
            0:       value = 16'd0;
            1:       value = 16'hFFFF;
            2:       value = 16'($urandom_range(1, 8));
            default: value = 16'($urandom_range(1, 120));
          endcase
          write_reg(CfgIdxTemplateSize, value);
        end
        @(negedge clk);
        count = $urandom_range(1, 48);
      end
      repeat (count) pending_bytes.push_back(8'($urandom_range(0, 255)));
      wait_for_drain();
      hold_req = 1'b0;
      random_queued += count;
    end

    wait_for_drain();
    $display("covered %0d template bytes and %0d wire beats in %0d packets",
             bytes_accepted, beats_checked, packets_seen);
    $display("%0d transfers closed across %0d register writes, including a long output hold",
             transfers_seen, cfg_writes);
    if (fail_count == 0 && wire_beats_due.size() == 0) begin
      $display("PASS sensor_packet_framer_top");
    end else begin
      $display("FAIL sensor_packet_framer_top");
    end
    $finish;
  end

endmodule
